@@ design/hnat_pkg.sv @@
// Shared types, constants and the note-to-divisor lookup for the held-note arpeggiator.
package hnat_pkg;

  localparam int unsigned MaxHeldDefault = 16;
  localparam int unsigned KindW = 2;
  localparam int unsigned NoteW = 7;
  localparam int unsigned DivW  = 16;
  localparam int unsigned BaseW = 18;

  typedef enum logic [KindW-1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_ALL_OFF  = 2'd2,
    KIND_TICK     = 2'd3
  } kind_e;

  typedef struct packed {
    logic            speaker_on;
    logic [DivW-1:0] tone_divisor;
    logic            divisor_written;
    logic            note_dropped;
  } res_t;

  // Divisor of note n: base divisor of its semitone shifted right by its octave.
  function automatic logic [DivW-1:0] divisor_of(input logic [NoteW-1:0] n);
    logic [3:0]       oct;
    logic [NoteW-1:0] semi;
    logic [BaseW-1:0] base;
    logic [BaseW-1:0] shifted;
    oct = 4'd0;
    for (int k = 1; k <= 10; k++) begin
      if (n >= NoteW'(12 * k)) oct = 4'(k);
    end
    semi = n - (NoteW'(oct) * NoteW'(12));
    case (semi[3:0])
      4'd0:    base = 18'd145940;
      4'd1:    base = 18'd137749;
      4'd2:    base = 18'd130018;
      4'd3:    base = 18'd122720;
      4'd4:    base = 18'd115833;
      4'd5:    base = 18'd109331;
      4'd6:    base = 18'd103195;
      4'd7:    base = 18'd97403;
      4'd8:    base = 18'd91936;
      4'd9:    base = 18'd86776;
      4'd10:   base = 18'd81906;
      4'd11:   base = 18'd77309;
      default: base = 18'd0;
    endcase
    shifted = base >> oct;
    return shifted[DivW-1:0];
  endfunction

endpackage

@@ design/hnat_ifs.sv @@
// Valid/ready channel interfaces for input items and result words.
interface hnat_in_if
  import hnat_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [NoteW-1:0] note;

  modport source (output valid, kind, note, input ready);
  modport sink   (input valid, kind, note, output ready);
endinterface

interface hnat_out_if
  import hnat_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            speaker_on;
  logic [DivW-1:0] tone_divisor;
  logic            divisor_written;
  logic            note_dropped;

  modport source (output valid, speaker_on, tone_divisor, divisor_written, note_dropped,
                  input ready);
  modport sink   (input valid, speaker_on, tone_divisor, divisor_written, note_dropped,
                  output ready);
endinterface

@@ design/hnat_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
module hnat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/hnat_seq.sv @@
// Sequencer: held-note list maintenance, chord stepping and divisor updates.
module hnat_seq
  import hnat_pkg::*;
#(
  parameter int unsigned MaxHeld = MaxHeldDefault,
  localparam int unsigned CntW = $clog2(MaxHeld + 1),
  localparam int unsigned IdxW = $clog2(MaxHeld)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [KindW-1:0] in_kind_i,
  input  logic [NoteW-1:0] in_note_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  output logic             mem_we_o,
  output logic [IdxW-1:0]  mem_waddr_o,
  output logic [NoteW-1:0] mem_wdata_o,
  output logic [IdxW-1:0]  mem_raddr_o,
  input  logic [NoteW-1:0] mem_rdata_i
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISP     = 3'd1;
  localparam logic [2:0] S_OFF_SCAN = 3'd2;
  localparam logic [2:0] S_OFF_RD0  = 3'd3;
  localparam logic [2:0] S_OFF_LD0  = 3'd4;
  localparam logic [2:0] S_TICK_LD  = 3'd5;
  localparam logic [2:0] S_DONE     = 3'd6;

  logic [2:0]       state_q, state_d;
  kind_e            kind_q, kind_d;
  logic [NoteW-1:0] note_q, note_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  cursor_q, cursor_d;
  logic             chord_q, chord_d;
  logic             gate_q, gate_d;
  logic [DivW-1:0]  div_q, div_d;
  logic             written_q, written_d;
  logic             dropped_q, dropped_d;
  logic             found_q, found_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  pend_idx_q, pend_idx_d;

  logic [CntW-1:0]  cnt_after;
  logic [CntW-1:0]  cur_inc;
  logic [IdxW-1:0]  cur_eff;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    note_d      = note_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    chord_d     = chord_q;
    gate_d      = gate_q;
    div_d       = div_q;
    written_d   = written_q;
    dropped_d   = dropped_q;
    found_d     = found_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = note_q;
    mem_raddr_o = '0;
    cnt_after   = found_q ? (count_q - 1'b1) : count_q;
    cur_inc     = CntW'(cursor_q) + 1'b1;
    cur_eff     = (CntW'(cursor_q) >= count_q) ? '0 : cursor_q;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          kind_d    = kind_e'(in_kind_i);
          note_d    = in_note_i;
          written_d = 1'b0;
          dropped_d = 1'b0;
          state_d   = S_DISP;
        end
      end
      S_DISP: begin
        unique case (kind_q)
          KIND_NOTE_ON: begin
            state_d = S_DONE;
            if (count_q == CntW'(MaxHeld)) begin
              dropped_d = 1'b1;
            end else begin
              mem_we_o    = 1'b1;
              mem_waddr_o = count_q[IdxW-1:0];
              count_d     = count_q + 1'b1;
              if (count_q == '0) begin
                div_d     = divisor_of(note_q);
                written_d = 1'b1;
                gate_d    = 1'b1;
                chord_d   = 1'b0;
              end else begin
                if (count_q == CntW'(1)) cursor_d = '0;
                chord_d = 1'b1;
              end
            end
          end
          KIND_NOTE_OFF: begin
            found_d  = 1'b0;
            rd_idx_d = '0;
            pend_d   = 1'b0;
            state_d  = S_OFF_SCAN;
          end
          KIND_ALL_OFF: begin
            count_d  = '0;
            cursor_d = '0;
            chord_d  = 1'b0;
            gate_d   = 1'b0;
            state_d  = S_DONE;
          end
          KIND_TICK: begin
            if (chord_q && (count_q >= CntW'(2))) begin
              mem_raddr_o = cur_eff;
              cursor_d    = cur_eff;
              state_d     = S_TICK_LD;
            end else begin
              state_d = S_DONE;
            end
          end
          default: state_d = S_DONE;
        endcase
      end
      S_OFF_SCAN: begin
        // Read entry i while entry i-1's data returns; after the match,
        // each later entry is written one slot lower.
        if (rd_idx_q < count_q) begin
          mem_raddr_o = rd_idx_q[IdxW-1:0];
          rd_idx_d    = rd_idx_q + 1'b1;
          pend_d      = 1'b1;
          pend_idx_d  = rd_idx_q[IdxW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (found_q) begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pend_idx_q - 1'b1;
            mem_wdata_o = mem_rdata_i;
          end else if (mem_rdata_i == note_q) begin
            found_d = 1'b1;
          end
        end
        if ((rd_idx_q >= count_q) && !pend_q) begin
          count_d = cnt_after;
          if (cnt_after == '0) begin
            gate_d  = 1'b0;
            chord_d = 1'b0;
            state_d = S_DONE;
          end else if ((cnt_after == CntW'(1)) && found_q) begin
            state_d = S_OFF_RD0;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_OFF_RD0: begin
        state_d = S_OFF_LD0;
      end
      S_OFF_LD0: begin
        div_d     = divisor_of(mem_rdata_i);
        written_d = 1'b1;
        chord_d   = 1'b0;
        state_d   = S_DONE;
      end
      S_TICK_LD: begin
        div_d     = divisor_of(mem_rdata_i);
        written_d = 1'b1;
        cursor_d  = (cur_inc >= count_q) ? '0 : cur_inc[IdxW-1:0];
        state_d   = S_DONE;
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_o.speaker_on      = gate_q;
  assign res_o.tone_divisor    = div_q;
  assign res_o.divisor_written = written_q;
  assign res_o.note_dropped    = dropped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cursor_q <= '0;
      chord_q  <= 1'b0;
      gate_q   <= 1'b0;
      div_q    <= '0;
      found_q  <= 1'b0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      chord_q  <= chord_d;
      gate_q   <= gate_d;
      div_q    <= div_d;
      found_q  <= found_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    note_q     <= note_d;
    written_q  <= written_d;
    dropped_q  <= dropped_d;
    pend_idx_q <= pend_idx_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxHeld))
    else $error("held count beyond capacity");

  a_gate_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (gate_q == (count_q != '0)))
    else $error("speaker gate out of step with held count");

  a_chord_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) && chord_q) |-> (count_q >= CntW'(2)))
    else $error("chord mode with fewer than two notes");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> ((state_q == S_DISP) || (state_q == S_OFF_SCAN)))
    else $error("list write outside note on or note off");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DISP))
    else $error("accepted word not dispatched");

endmodule

@@ design/held_note_arpeggiator_tone_top.sv @@
// Top level of the held-note arpeggiator: list RAM, sequencer and result register.
//
// Held notes live in a MaxHeld-entry RAM with a registered read. A word is
// taken when the sequencer is idle; its result lands in an output register so the
// next word can be taken while the result waits. A chord tick reads its note from
// the RAM, and a note off walks the list: the note-off search and gap closing go
// through the RAM's single read port one entry per cycle, and when one note remains
// its entry is read back for the new divisor.
module held_note_arpeggiator_tone_top
  import hnat_pkg::*;
#(
  parameter int unsigned MaxHeld = MaxHeldDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hnat_in_if.sink    item_i,
  hnat_out_if.source result_o
);

  localparam int unsigned IdxW = $clog2(MaxHeld);

  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  logic [NoteW-1:0] mem_wdata;
  logic [IdxW-1:0]  mem_raddr;
  logic [NoteW-1:0] mem_rdata;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic             out_valid_q, out_valid_d;
  res_t             out_q;

  hnat_ram #(
    .Width (NoteW),
    .Depth (MaxHeld)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  hnat_seq #(
    .MaxHeld (MaxHeld)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .in_kind_i   (item_i.kind),
    .in_note_i   (item_i.note),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Output slot frees up in the cycle its word is taken.
  assign res_ready = !out_valid_q || result_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.speaker_on      = out_q.speaker_on;
  assign result_o.tone_divisor    = out_q.tone_divisor;
  assign result_o.divisor_written = out_q.divisor_written;
  assign result_o.note_dropped    = out_q.note_dropped;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the held-note arpeggiator: queued stimulus, word-level predictor, result checks.
module tb
  import hnat_pkg::*;
();

  localparam int unsigned MaxHeld     = MaxHeldDefault;
  localparam int          RandomWords = 1060;
  localparam int          TailWords   = 120;
  localparam int          DrainCycles = 40;
  localparam int          StallLimit  = 2000;
  localparam int          HoldAfter   = 300;
  localparam int          HoldCycles  = 400;

  typedef struct {
    kind_e            kind;
    logic [NoteW-1:0] note;
  } word_t;

  logic clk_i;
  logic rst_ni;

  hnat_in_if  in_if ();
  hnat_out_if out_if ();

  held_note_arpeggiator_tone_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_if),
    .result_o (out_if)
  );

  word_t            pending_words [$];
  res_t             due_results [$];
  logic [NoteW-1:0] gen_held [$];      // generator's view of the held list

  // predicted block state
  logic [NoteW-1:0] held_list [MaxHeld];
  int               held_n = 0;
  int               cursor = 0;
  logic             chord = 1'b0;
  logic             gate = 1'b0;
  logic [DivW-1:0]  cur_div = '0;

  int          errors = 0;
  int          results_seen = 0;
  int          send_gap, recv_gap, hold_left, quiet_cycles;
  logic        hold_done;
  logic [15:0] phase_cnt = '0;
  logic        idle_on = 1'b1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [DivW-1:0] tone_div(input logic [NoteW-1:0] n);
    int unsigned base;
    case (n % 12)
      0:       base = 145940;
      1:       base = 137749;
      2:       base = 130018;
      3:       base = 122720;
      4:       base = 115833;
      5:       base = 109331;
      6:       base = 103195;
      7:       base = 97403;
      8:       base = 91936;
      9:       base = 86776;
      10:      base = 81906;
      default: base = 77309;
    endcase
    return DivW'(base >> (n / 12));
  endfunction

  function automatic res_t step_arpeggiator(input kind_e kind, input logic [NoteW-1:0] note);
    res_t r;
    logic found;
    int   i;
    r = '0;
    found = 1'b0;
    case (kind)
      KIND_NOTE_ON: begin
        if (held_n >= MaxHeld) begin
          r.note_dropped = 1'b1;
        end else begin
          held_list[held_n] = note;
          held_n++;
          if (held_n == 1) begin
            cur_div = tone_div(note);
            r.divisor_written = 1'b1;
            gate = 1'b1;
            chord = 1'b0;
          end else begin
            if (held_n == 2) cursor = 0;
            chord = 1'b1;
          end
        end
      end
      KIND_NOTE_OFF: begin
        // first match goes, later entries slide down one
        for (i = 0; i < held_n; i++) begin
          if (!found && held_list[i] == note) found = 1'b1;
          if (found && i + 1 < held_n) held_list[i] = held_list[i+1];
        end
        if (found) held_n--;
        if (held_n == 0) begin
          gate = 1'b0;
          chord = 1'b0;
        end else if (held_n == 1 && found) begin
          cur_div = tone_div(held_list[0]);
          r.divisor_written = 1'b1;
          chord = 1'b0;
        end
      end
      KIND_ALL_OFF: begin
        held_n = 0;
        cursor = 0;
        chord = 1'b0;
        gate = 1'b0;
      end
      default: begin
        if (chord && held_n >= 2) begin
          if (cursor >= held_n) cursor = 0;
          cur_div = tone_div(held_list[cursor]);
          r.divisor_written = 1'b1;
          cursor++;
          if (cursor >= held_n) cursor = 0;
        end
      end
    endcase
    r.speaker_on = gate;
    r.tone_divisor = cur_div;
    return r;
  endfunction

  function automatic void queue_word(input kind_e kind, input logic [NoteW-1:0] note);
    int i;
    word_t w;
    w.kind = kind;
    w.note = note;
    pending_words.push_back(w);
    case (kind)
      KIND_NOTE_ON:  if (gen_held.size() < MaxHeld) gen_held.push_back(note);
      KIND_NOTE_OFF: begin
        for (i = 0; i < gen_held.size(); i++) begin
          if (gen_held[i] == note) begin
            gen_held.delete(i);
            break;
          end
        end
      end
      KIND_ALL_OFF:  gen_held.delete();
      default:       ;
    endcase
  endfunction

  // half wide-open, half a narrow band so duplicates are common
  function automatic logic [NoteW-1:0] rand_note();
    if ($urandom_range(0, 1) != 0) return NoteW'($urandom_range(0, 127));
    return NoteW'($urandom_range(58, 65));
  endfunction

  function automatic logic [NoteW-1:0] off_note();
    if (gen_held.size() != 0 && $urandom_range(0, 4) != 0)
      return gen_held[$urandom_range(0, gen_held.size() - 1)];
    return rand_note();
  endfunction

  task automatic cmp_field(input string name, input logic [DivW-1:0] want,
                           input logic [DivW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int r, p_on, words_goal;
    rst_ni = 1'b0;

    queue_word(KIND_TICK, 7'd0);        // tick with nothing held
    queue_word(KIND_NOTE_OFF, 7'd60);   // note off on an empty list
    queue_word(KIND_ALL_OFF, 7'd0);
    queue_word(KIND_NOTE_ON, 7'd127);   // first note
    queue_word(KIND_NOTE_OFF, 7'd3);    // no match, one held
    queue_word(KIND_TICK, 7'd0);        // tick outside chord
    queue_word(KIND_NOTE_ON, 7'd0);     // enter chord
    queue_word(KIND_NOTE_ON, 7'd127);   // duplicate
    repeat (4) queue_word(KIND_TICK, 7'd0);
    queue_word(KIND_NOTE_OFF, 7'd127);  // removes first copy only
    queue_word(KIND_NOTE_ON, 7'd85);
    queue_word(KIND_TICK, 7'd0);
    queue_word(KIND_NOTE_OFF, 7'd0);    // cursor may now be stale
    queue_word(KIND_TICK, 7'd0);
    queue_word(KIND_NOTE_OFF, 7'd85);   // back to one note
    queue_word(KIND_NOTE_OFF, 7'd127);  // last note off
    queue_word(KIND_NOTE_ON, 7'd42);
    queue_word(KIND_NOTE_ON, 7'd42);
    queue_word(KIND_NOTE_OFF, 7'd42);
    queue_word(KIND_NOTE_ON, 7'd64);
    queue_word(KIND_ALL_OFF, 7'd0);
    queue_word(KIND_TICK, 7'd0);

    words_goal = pending_words.size() + RandomWords;
    while (pending_words.size() < words_goal) begin
      r = $urandom_range(0, 9);
      if (r == 0) begin
        // fill the list, overflow it, then step through the chord
        while (gen_held.size() < MaxHeld) queue_word(KIND_NOTE_ON, rand_note());
        repeat ($urandom_range(1, 3)) queue_word(KIND_NOTE_ON, rand_note());
        repeat ($urandom_range(2, 20)) queue_word(KIND_TICK, rand_note());
      end else if (r == 1) begin
        repeat (10) queue_word(kind_e'($urandom_range(0, 3)), NoteW'($urandom_range(0, 127)));
      end else begin
        case ($urandom_range(0, 3))
          0:       p_on = 15;
          1:       p_on = 30;
          2:       p_on = 45;
          default: p_on = 55;
        endcase
        repeat (40) begin
          r = $urandom_range(0, 99);
          if (r < 2)              queue_word(KIND_ALL_OFF, rand_note());
          else if (r < 40)        queue_word(KIND_TICK, rand_note());
          else if (r < 40 + p_on) queue_word(KIND_NOTE_ON, rand_note());
          else                    queue_word(KIND_NOTE_OFF, off_note());
        end
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pending_words.size() != 0 || in_if.valid || due_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // idle bursts are switched on and off whenever the low eight bits of the phase counter are zero
  always @(posedge clk_i) begin
    phase_cnt <= phase_cnt + 1'b1;
    if (phase_cnt[7:0] == 8'd0) idle_on <= ($urandom_range(0, 3) != 0);
  end

  // word driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.kind  <= KIND_NOTE_ON;
      in_if.note  <= '0;
      send_gap    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap != 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (pending_words.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (idle_on && pending_words.size() > TailWords &&
                   $urandom_range(0, 9) == 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= $urandom_range(0, 16);
      end else begin
        in_if.valid <= 1'b1;
        in_if.kind  <= pending_words[0].kind;
        in_if.note  <= pending_words[0].note;
        void'(pending_words.pop_front());
      end
    end
  end

  // predict on every accepted input word
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      due_results.push_back(step_arpeggiator(kind_e'(in_if.kind), in_if.note));
  end

  // result monitor and ready driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
      hold_left    <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with no word outstanding, expected none, got divisor %0d",
                   $time, out_if.tone_divisor);
          errors++;
        end else begin
          cmp_field("speaker_on", DivW'(due_results[0].speaker_on), DivW'(out_if.speaker_on));
          cmp_field("tone_divisor", due_results[0].tone_divisor, out_if.tone_divisor);
          cmp_field("divisor_written", DivW'(due_results[0].divisor_written),
                    DivW'(out_if.divisor_written));
          cmp_field("note_dropped", DivW'(due_results[0].note_dropped),
                    DivW'(out_if.note_dropped));
          void'(due_results.pop_front());
        end
        results_seen++;
      end
      // one long hold-off lets the block back up into its input
      if (!hold_done && results_seen == HoldAfter) begin
        out_if.ready <= 1'b0;
        hold_left    <= HoldCycles;
        hold_done    <= 1'b1;
      end else if (hold_left != 0) begin
        out_if.ready <= 1'b0;
        hold_left    <= hold_left - 1;
      end else if (recv_gap != 0) begin
        out_if.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else if (idle_on && pending_words.size() > TailWords &&
                   $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        recv_gap     <= $urandom_range(0, 16);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ sim.f @@
design/hnat_pkg.sv
design/hnat_ifs.sv
design/hnat_ram.sv
design/hnat_seq.sv
design/held_note_arpeggiator_tone_top.sv
test/tb.sv
